>>> rtl/core/c2s_pkg.sv
// ============================================================================
// c2s_pkg
// Shared types and constants for the Cartesian-to-spherical CORDIC converter.
// ============================================================================
package c2s_pkg;

    // Datapath word width of the CORDIC rotators, and width of the angle
    // accumulator (2^31 stands for pi, range about -pi/2 .. 3pi/2).
    localparam int DATA_W  = 64;
    localparam int ANGLE_W = 34;

    typedef logic [DATA_W-1:0]          word_t;
    typedef logic signed [ANGLE_W-1:0]  angle_t;

    // Converged inverse CORDIC gain as a 32-bit fraction.
    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

    // Pi in accumulator units, and the rounding offset for the 16-bit angles.
    localparam angle_t HALF_TURN   = 34'sh0_8000_0000;
    localparam angle_t ANGLE_ROUND = 34'sh0_0000_8000;

    // atan(2^-i) with 2^31 standing for pi, rounded to nearest.
    localparam int ATAN_N = 32;
    localparam logic [29:0] ATAN_TABLE [ATAN_N] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // State of one vector while it moves through a vectoring pass.
    typedef struct packed {
        word_t  x;
        word_t  y;
        angle_t angle;
        logic   zero;
    } cordic_t;

endpackage

>>> rtl/core/c2s_cordic_stage.sv
// ============================================================================
// c2s_cordic_stage
// One registered CORDIC vectoring micro-rotation by atan(2^-SHIFT).
// ============================================================================
module c2s_cordic_stage #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  c2s_pkg::cordic_t     up_data,
    input  logic [SIDE_W-1:0]    up_side,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output c2s_pkg::cordic_t     dn_data,
    output logic [SIDE_W-1:0]    dn_side
);
    import c2s_pkg::*;

    localparam angle_t STEP_ANGLE = angle_t'(ATAN_TABLE[SHIFT]);

    logic              valid_reg;
    cordic_t           data_reg;
    cordic_t           data_next;
    logic [SIDE_W-1:0] side_reg;
    word_t             dx;
    word_t             dy;

    // The stage takes a new transfer when it is empty or its contents move on.
    assign up_ready = !valid_reg || dn_ready;

    // Rotate toward the x axis; both updates use the values from before the step.
    assign dx = word_t'($signed(up_data.y) >>> SHIFT);
    assign dy = word_t'($signed(up_data.x) >>> SHIFT);

    always_comb
    begin
        data_next      = up_data;
        if (!up_data.y[DATA_W-1])
        begin
            data_next.x     = up_data.x + dx;
            data_next.y     = up_data.y - dy;
            data_next.angle = up_data.angle + STEP_ANGLE;
        end
        else
        begin
            data_next.x     = up_data.x - dx;
            data_next.y     = up_data.y + dy;
            data_next.angle = up_data.angle - STEP_ANGLE;
        end
    end

    // Valid bit travels with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign dn_side  = side_reg;

endmodule

>>> rtl/core/c2s_vector_pass.sv
// ============================================================================
// c2s_vector_pass
// Pipelined CORDIC vectoring pass: half-plane fold, micro-rotations and
// gain compensation. Returns the magnitude and the angle of (x, y).
// ============================================================================
module c2s_vector_pass #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  c2s_pkg::word_t       up_x,
    input  c2s_pkg::word_t       up_y,
    input  logic [SIDE_W-1:0]    up_side,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output c2s_pkg::word_t       dn_mag,
    output c2s_pkg::angle_t      dn_angle,
    output logic [SIDE_W-1:0]    dn_side
);
    import c2s_pkg::*;

    // ------------------------------------------------------------------
    // Fold stage: bring the vector into the right half plane.
    // ------------------------------------------------------------------
    logic              fold_valid_reg;
    cordic_t           fold_reg;
    cordic_t           fold_next;
    logic [SIDE_W-1:0] fold_side_reg;

    logic              chain_valid [STAGES+1];
    logic              chain_ready [STAGES+1];
    cordic_t           chain_data  [STAGES+1];
    logic [SIDE_W-1:0] chain_side  [STAGES+1];

    always_comb
    begin
        fold_next.zero = (up_x == '0) && (up_y == '0);
        if (up_x[DATA_W-1])
        begin
            fold_next.x     = '0 - up_x;
            fold_next.y     = '0 - up_y;
            fold_next.angle = HALF_TURN;
        end
        else
        begin
            fold_next.x     = up_x;
            fold_next.y     = up_y;
            fold_next.angle = '0;
        end
    end

    assign up_ready = !fold_valid_reg || chain_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else if (up_ready)
            fold_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            fold_reg      <= fold_next;
            fold_side_reg <= up_side;
        end
    end

    assign chain_valid[0] = fold_valid_reg;
    assign chain_data[0]  = fold_reg;
    assign chain_side[0]  = fold_side_reg;

    // ------------------------------------------------------------------
    // Micro-rotation stages, one register stage per iteration.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < STAGES; k++)
    begin : g_rot
        c2s_cordic_stage #(
            .SHIFT  (k),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_data  (chain_data[k]),
            .up_side  (chain_side[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_data  (chain_data[k+1]),
            .dn_side  (chain_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Gain compensation, first half: two 32x32 partial products.
    // ------------------------------------------------------------------
    logic              mul_valid_reg;
    logic              mul_ready;
    word_t             prod_hi_reg;
    word_t             prod_lo_reg;
    angle_t            mul_angle_reg;
    logic              mul_zero_reg;
    logic [SIDE_W-1:0] mul_side_reg;
    word_t             prod_hi_next;
    word_t             prod_lo_next;
    logic              add_ready;

    assign prod_hi_next = word_t'(chain_data[STAGES].x[63:32]) * word_t'(INV_GAIN);
    assign prod_lo_next = word_t'(chain_data[STAGES].x[31:0]) * word_t'(INV_GAIN);

    assign mul_ready           = !mul_valid_reg || add_ready;
    assign chain_ready[STAGES] = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (mul_ready)
            mul_valid_reg <= chain_valid[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[STAGES] && mul_ready)
        begin
            prod_hi_reg   <= prod_hi_next;
            prod_lo_reg   <= prod_lo_next;
            mul_angle_reg <= chain_data[STAGES].angle;
            mul_zero_reg  <= chain_data[STAGES].zero;
            mul_side_reg  <= chain_side[STAGES];
        end
    end

    // ------------------------------------------------------------------
    // Gain compensation, second half: round and sum the partial products.
    // A zero vector reports angle zero.
    // ------------------------------------------------------------------
    logic              add_valid_reg;
    word_t             mag_reg;
    word_t             mag_next;
    angle_t            angle_reg;
    angle_t            angle_next;
    logic [SIDE_W-1:0] side_reg;
    logic [DATA_W:0]   lo_round;

    assign lo_round   = {1'b0, prod_lo_reg} + (DATA_W+1)'(33'h0_8000_0000);
    assign mag_next   = prod_hi_reg + word_t'(lo_round[DATA_W:32]);
    assign angle_next = mul_zero_reg ? angle_t'(0) : mul_angle_reg;

    assign add_ready = !add_valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            add_valid_reg <= 1'b0;
        else if (add_ready)
            add_valid_reg <= mul_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg && add_ready)
        begin
            mag_reg   <= mag_next;
            angle_reg <= angle_next;
            side_reg  <= mul_side_reg;
        end
    end

    assign dn_valid = add_valid_reg;
    assign dn_mag   = mag_reg;
    assign dn_angle = angle_reg;
    assign dn_side  = side_reg;

endmodule

>>> rtl/core/cartesian_to_spherical.sv
// ============================================================================
// cartesian_to_spherical
// Converts a 3-D point in Q16.16 fixed point to radius, polar angle and
// azimuth with two pipelined CORDIC vectoring passes.
// ============================================================================
// The block accepts one point per clock cycle while point_stall is low and
// returns one result per point, in order. Each point passes from its input
// transfer to its result through two vectoring passes and a final stage:
// each pass has a fold stage, one register stage per CORDIC iteration and
// two gain compensation stages, and the final stage rounds the radius and
// the polar angle; the azimuth is rounded on its way into the second pass.
// The first pass vectors (x, y) into rho and the azimuth, the second
// vectors (z, rho) into the radius and the polar angle.
// Angles are binary angles in which 32768 stands for pi; the polar angle is
// clamped to 0..pi and the azimuth wraps, so the negative x axis reads as
// -32768. For the origin both angles are 0 and zero_vector is set. A stage
// holds its contents only while the stage after it is full and stalled, so
// empty stages keep filling while a result waits at the output.
module cartesian_to_spherical #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    output logic                          point_stall,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [31:0]                   radius,
    output logic [15:0]                   polar_angle,
    output logic signed [15:0]            azimuth,
    output logic                          zero_vector
);
    import c2s_pkg::*;

    localparam int GUARD_BITS = 60 - COORD_WIDTH;
    localparam int SIDE1_W    = COORD_WIDTH + 1;
    localparam int SIDE2_W    = 17;

    // ------------------------------------------------------------------
    // Input alignment: sign-extend and add guard bits.
    // ------------------------------------------------------------------
    word_t               x_ld;
    word_t               y_ld;
    logic                all_zero;
    logic [SIDE1_W-1:0]  side1_in;
    logic                p1_ready;

    assign x_ld     = word_t'(coord_x) << GUARD_BITS;
    assign y_ld     = word_t'(coord_y) << GUARD_BITS;
    assign all_zero = (coord_x == '0) && (coord_y == '0) && (coord_z == '0);
    assign side1_in = {all_zero, coord_z};

    assign point_stall = !p1_ready;

    // ------------------------------------------------------------------
    // First pass: (x, y) gives rho and the azimuth.
    // ------------------------------------------------------------------
    logic                p1_valid;
    logic                p2_ready;
    word_t               rho;
    angle_t              theta;
    logic [SIDE1_W-1:0]  side1_out;

    c2s_vector_pass #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE1_W)
    ) u_pass_xy (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (point_valid),
        .up_ready (p1_ready),
        .up_x     (x_ld),
        .up_y     (y_ld),
        .up_side  (side1_in),
        .dn_valid (p1_valid),
        .dn_ready (p2_ready),
        .dn_mag   (rho),
        .dn_angle (theta),
        .dn_side  (side1_out)
    );

    // ------------------------------------------------------------------
    // Between passes: realign z and round the azimuth to 16 bits.
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] z_mid;
    word_t                         z_ld;
    angle_t                        theta_sum;
    logic [SIDE2_W-1:0]            side2_in;

    assign z_mid     = side1_out[COORD_WIDTH-1:0];
    assign z_ld      = word_t'(z_mid) << GUARD_BITS;
    assign theta_sum = theta + ANGLE_ROUND;
    assign side2_in  = {side1_out[COORD_WIDTH], theta_sum[31:16]};

    // ------------------------------------------------------------------
    // Second pass: (z, rho) gives the radius and the polar angle.
    // ------------------------------------------------------------------
    logic                p2_valid;
    logic                out_ready;
    word_t               r_mag;
    angle_t              phi;
    logic [SIDE2_W-1:0]  side2_out;

    c2s_vector_pass #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE2_W)
    ) u_pass_zr (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (p1_valid),
        .up_ready (p2_ready),
        .up_x     (z_ld),
        .up_y     (rho),
        .up_side  (side2_in),
        .dn_valid (p2_valid),
        .dn_ready (out_ready),
        .dn_mag   (r_mag),
        .dn_angle (phi),
        .dn_side  (side2_out)
    );

    // ------------------------------------------------------------------
    // Output stage: round and saturate the radius, clamp and round phi.
    // ------------------------------------------------------------------
    word_t        rad_sum;
    word_t        rad_wide;
    logic [31:0]  radius_next;
    angle_t       phi_clamp;
    angle_t       phi_sum;

    assign rad_sum     = r_mag + (word_t'(1) << (GUARD_BITS - 1));
    assign rad_wide    = rad_sum >> GUARD_BITS;
    assign radius_next = (rad_wide[DATA_W-1:32] != '0) ? 32'hFFFF_FFFF : rad_wide[31:0];

    always_comb
    begin
        if (phi[ANGLE_W-1])
            phi_clamp = '0;
        else if (phi > HALF_TURN)
            phi_clamp = HALF_TURN;
        else
            phi_clamp = phi;
    end

    assign phi_sum = phi_clamp + ANGLE_ROUND;

    logic               result_valid_reg;
    logic [31:0]        radius_reg;
    logic [15:0]        polar_angle_reg;
    logic signed [15:0] azimuth_reg;
    logic               zero_vector_reg;

    assign out_ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_ready)
            result_valid_reg <= p2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid && out_ready)
        begin
            radius_reg      <= radius_next;
            polar_angle_reg <= phi_sum[31:16];
            azimuth_reg     <= side2_out[15:0];
            zero_vector_reg <= side2_out[16];
        end
    end

    assign result_valid = result_valid_reg;
    assign radius       = radius_reg;
    assign polar_angle  = polar_angle_reg;
    assign azimuth      = azimuth_reg;
    assign zero_vector  = zero_vector_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The origin yields an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_vector |-> radius == '0 && polar_angle == '0 && azimuth == '0)
    else $error("origin result is not all zero");

    // The polar angle never exceeds pi.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> polar_angle <= 16'd32768)
    else $error("polar angle above pi");

    // With an empty output register every stage can move, so input is never stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !point_stall)
    else $error("input stalled while the output register is empty");

endmodule
